// ===== hw/rtl/nirs_pkg.sv =====
// ----------------------------------------------------------------------------
// nirs_pkg: shared types and constants of the nearest-in-radius selector
// Widths of the coordinate, distance and identifier fields, the kept-list
// types and the configuration register indexes.
// ----------------------------------------------------------------------------
package nirs_pkg;

  localparam int MAX_TARGETS = 3;
  localparam int COORD_W     = 12;
  localparam int SQ_W        = 2 * COORD_W;      // one squared difference
  localparam int DIST_W      = SQ_W + 1;         // sum of two squares
  localparam int IDX_W       = 16;
  localparam int RANK_W      = 2;
  localparam int CNT_W       = $clog2(MAX_TARGETS + 1);
  localparam int CFG_IDX_W   = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SQ_W-1:0]    sq_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [RANK_W-1:0]  rank_t;

  typedef struct packed {
    dist_t dsq;
    idx_t  idx;
  } entry_t;

  typedef entry_t [MAX_TARGETS-1:0] list_t;

  // Control from the top level to the kept list
  typedef struct packed {
    logic upd;   // insert the current point
    logic clr;   // set closes on this item: empty the list
  } list_ctl_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_RADIUS   = 2'd2,
    REG_MULTI    = 2'd3
  } cfg_reg_t;

endpackage

// ===== hw/rtl/nirs_list.sv =====
// ----------------------------------------------------------------------------
// nirs_list: sorted list of the nearest kept points
// Holds up to MAX_TARGETS entries in ascending distance order and inserts
// one point per cycle; equal distances go behind the entries already kept.
// ----------------------------------------------------------------------------
module nirs_list import nirs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  list_ctl_t ctl,
  input  dist_t     pt_dsq,
  input  idx_t      idx,
  output list_t     list_ins,
  output cnt_t      count_ins
);

  list_t entries_r;
  cnt_t  count_r;
  cnt_t  pos;

  always_comb begin
    pos = '0;
    for (int j = 0; j < MAX_TARGETS; j++) begin
      if ((CNT_W'(j) < count_r) && (entries_r[j].dsq <= pt_dsq)) begin
        pos = pos + 1'b1;
      end
    end
  end

  // Insert at pos; a full list with pos beyond the end drops the point
  always_comb begin
    list_ins = entries_r;
    if (ctl.upd) begin
      for (int j = 1; j < MAX_TARGETS; j++) begin
        if (CNT_W'(j) > pos) begin
          list_ins[j] = entries_r[j-1];
        end
      end
      for (int j = 0; j < MAX_TARGETS; j++) begin
        if (CNT_W'(j) == pos) begin
          list_ins[j].dsq = pt_dsq;
          list_ins[j].idx = idx;
        end
      end
    end
    if (ctl.upd && (count_r < CNT_W'(MAX_TARGETS))) begin
      count_ins = count_r + 1'b1;
    end else begin
      count_ins = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.clr) begin
      count_r <= '0;
    end else begin
      count_r <= count_ins;
    end
  end

  always_ff @(posedge clk) begin
    entries_r <= list_ins;
  end

endmodule

// ===== hw/rtl/nearest_in_radius_selector_core.sv =====
// ----------------------------------------------------------------------------
// nearest_in_radius_selector_core: nearest points within a radius
// Measures each candidate's squared distance from the origin, keeps the
// nearest ones inside the radius and emits them when the set closes.
// ----------------------------------------------------------------------------
//
//   channel  | handshake             | carries
//   ---------+-----------------------+------------------------------------------
//   in_      | in_valid / in_ready   | point_x, point_y, point_index, present,
//            |                       | last_point
//   out_     | out_valid / out_ready | target_index, target_dist_sq, found,
//            |                       | rank, last_result
//   cfg_     | cfg_we                | cfg_index selects the register, cfg_data
//
// One item a cycle is taken while the input is not held. Stage one squares
// the coordinate differences and the radius; stage two sums, compares with
// the radius and inserts into the sorted list. An item that closes a set
// copies the list into the result queue, which drains one result a cycle
// while out_ready is high; 1 to MAX_TARGETS results per set. A closing item
// waits in stage two until the queue is empty or its final result is
// accepted in that cycle, and that holds the input. Reset is synchronous and
// clears the list count, the queue and the registers; no clearing pass.
// ----------------------------------------------------------------------------
module nearest_in_radius_selector_core import nirs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  // input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   in_point_x,
  input  logic [COORD_W-1:0]   in_point_y,
  input  logic [IDX_W-1:0]     in_point_index,
  input  logic                 in_present,
  input  logic                 in_last_point,
  // result items
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_target_index,
  output logic [DIST_W-1:0]    out_target_dist_sq,
  output logic                 out_found,
  output logic [RANK_W-1:0]    out_rank,
  output logic                 out_last_result
);

  // Configuration registers
  coord_t origin_x_r, origin_y_r, radius_r;
  logic   multi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      radius_r   <= '0;
      multi_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X: origin_x_r <= cfg_data;
        REG_ORIGIN_Y: origin_y_r <= cfg_data;
        REG_RADIUS:   radius_r   <= cfg_data;
        REG_MULTI:    multi_r    <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // Stage one: absolute differences and squares
  coord_t dx, dy;
  sq_t    dx2_nxt, dy2_nxt, r2_nxt;

  always_comb begin
    dx      = (in_point_x >= origin_x_r) ? (in_point_x - origin_x_r)
                                         : (origin_x_r - in_point_x);
    dy      = (in_point_y >= origin_y_r) ? (in_point_y - origin_y_r)
                                         : (origin_y_r - in_point_y);
    dx2_nxt = SQ_W'(dx) * SQ_W'(dx);
    dy2_nxt = SQ_W'(dy) * SQ_W'(dy);
    r2_nxt  = SQ_W'(radius_r) * SQ_W'(radius_r);
  end

  logic   s1_valid_r;
  sq_t    s1_dx2_r, s1_dy2_r, s1_r2_r;
  idx_t   s1_idx_r;
  logic   s1_present_r, s1_last_r;
  logic   s1_fire;
  logic   in_fire;

  // Result queue state
  logic   q_valid_r;
  list_t  q_r;
  logic   q_found_r;
  cnt_t   q_left_r;
  rank_t  q_rank_r;
  logic   q_pop, q_last, load_ok;

  assign q_last  = (q_left_r == CNT_W'(1));
  assign q_pop   = q_valid_r && out_ready;
  // Queue can take a new set when empty or when its final result leaves now
  assign load_ok = !q_valid_r || (q_pop && q_last);

  assign s1_fire  = s1_valid_r && (!s1_last_r || load_ok);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_dx2_r     <= dx2_nxt;
      s1_dy2_r     <= dy2_nxt;
      s1_r2_r      <= r2_nxt;
      s1_idx_r     <= in_point_index;
      s1_present_r <= in_present;
      s1_last_r    <= in_last_point;
    end
  end

  // Stage two: sum, range check and insertion
  dist_t     pt_dsq;
  logic      in_range;
  list_ctl_t list_ctl;
  list_t     list_ins;
  cnt_t      count_ins;

  assign pt_dsq       = DIST_W'(s1_dx2_r) + DIST_W'(s1_dy2_r);
  assign in_range     = pt_dsq <= DIST_W'(s1_r2_r);
  assign list_ctl.upd = s1_fire && s1_present_r && in_range;
  assign list_ctl.clr = s1_fire && s1_last_r;

  nirs_list u_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (list_ctl),
    .pt_dsq    (pt_dsq),
    .idx       (s1_idx_r),
    .list_ins  (list_ins),
    .count_ins (count_ins)
  );

  // Result queue: load a closed set, shift one entry out per accepted result
  logic load;
  logic set_found;
  assign load      = list_ctl.clr;
  assign set_found = (count_ins != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (load) begin
      q_valid_r <= 1'b1;
    end else if (q_pop && q_last) begin
      q_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_found_r <= set_found;
      q_rank_r  <= '0;
      q_r       <= set_found ? list_ins : '0;
      if (set_found && multi_r) begin
        q_left_r <= count_ins;
      end else begin
        q_left_r <= CNT_W'(1);
      end
    end else if (q_pop) begin
      q_rank_r <= RANK_W'(q_rank_r + 1'b1);
      q_left_r <= q_left_r - 1'b1;
      for (int j = 0; j < MAX_TARGETS - 1; j++) begin
        q_r[j] <= q_r[j+1];
      end
    end
  end

  assign out_valid          = q_valid_r;
  assign out_target_index   = q_r[0].idx;
  assign out_target_dist_sq = q_r[0].dsq;
  assign out_found          = q_found_r;
  assign out_rank           = q_rank_r;
  assign out_last_result    = q_last;

endmodule

// ===== hw/rtl/nirs_checker.sv =====
// ----------------------------------------------------------------------------
// nirs_checker: port-level checks of the nearest-in-radius selector
// Watches the result channel for ordering of ranks and the not-found form.
// ----------------------------------------------------------------------------
module nirs_checker import nirs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [IDX_W-1:0]  out_target_index,
  input logic [DIST_W-1:0] out_target_dist_sq,
  input logic              out_found,
  input logic [RANK_W-1:0] out_rank,
  input logic              out_last_result
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_target_index)
      && $stable(out_target_dist_sq) && $stable(out_rank))
    else $error("result changed while stalled");

  // Not found is a lone result of rank zero
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last_result && (out_rank == '0))
    else $error("malformed not-found result");

  // Within a set the next result follows at once with the next rank
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_result |=>
      out_valid && out_found && (out_rank == RANK_W'($past(out_rank) + 1'b1)))
    else $error("rank sequence broken");

  // Results within a set come nearest first
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_result |=>
      out_target_dist_sq >= $past(out_target_dist_sq))
    else $error("results not in ascending distance");

endmodule

bind nearest_in_radius_selector_core nirs_checker u_nirs_checker (.*);
